/* hdl/hrlp_pkg.sv */
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types and constants for the request line parser: phase codes,
// field tags, separator characters and the per-word result record.
// ----------------------------------------------------------------------------
package hrlp_pkg;

	// parse phase of the current request line
	typedef enum logic [2:0] {
		PH_METHOD = 3'd0,
		PH_PATH   = 3'd1,
		PH_QUERY  = 3'd2,
		PH_AFTER  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// field tag codes
	localparam logic [1:0] TAG_NONE   = 2'd0;
	localparam logic [1:0] TAG_METHOD = 2'd1;
	localparam logic [1:0] TAG_PATH   = 2'd2;
	localparam logic [1:0] TAG_QUERY  = 2'd3;

	// separator characters
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_QM = 8'h3F;

	// one result word
	typedef struct packed {
		logic [1:0] field_tag;
		logic [7:0] char_index;
		logic [7:0] char_value;
		logic       finished;
		logic       parse_failed;
	} result_t;

endpackage

/* hdl/hrlp_core.sv */
// ----------------------------------------------------------------------------
// hrlp_core
// Parse state and per-byte classification: holds phase, field counters and
// the error flag, and computes the result word for the byte presented.
// ----------------------------------------------------------------------------
module hrlp_core #(
	parameter int METHOD_LIMIT = 16,
	parameter int PATH_LIMIT   = 256,
	parameter int QUERY_LIMIT  = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              end_of_buffer,
	output hrlp_pkg::result_t res,
	output logic              at_start
);

	localparam int MW = $clog2(METHOD_LIMIT + 1);
	localparam int PW = $clog2(PATH_LIMIT + 1);
	localparam int QW = $clog2(QUERY_LIMIT + 1);
	localparam logic [MW-1:0] MLIM = MW'(METHOD_LIMIT);
	localparam logic [PW-1:0] PLIM = PW'(PATH_LIMIT);
	localparam logic [QW-1:0] QLIM = QW'(QUERY_LIMIT);

	hrlp_pkg::phase_t phase_q, phase_d;
	logic [MW-1:0]    mcnt_q, mcnt_d;
	logic [PW-1:0]    pcnt_q, pcnt_d;
	logic [QW-1:0]    qcnt_q, qcnt_d;
	logic             err_q, err_d;
	logic             is_eol;
	logic [MW-1:0]    mpos;
	logic [PW-1:0]    ppos;
	logic [QW-1:0]    qpos;

	assign is_eol = (byte_in == hrlp_pkg::CH_CR) || (byte_in == hrlp_pkg::CH_LF);

	// next count and position per field, held at the limit
	always_comb begin
		mpos = (mcnt_q < MLIM) ? mcnt_q + MW'(1) : mcnt_q;
		ppos = (pcnt_q < PLIM) ? pcnt_q + PW'(1) : pcnt_q;
		qpos = (qcnt_q < QLIM) ? qcnt_q + QW'(1) : qcnt_q;
	end

	// classify byte and compute next state
	always_comb begin
		phase_d        = phase_q;
		mcnt_d         = mcnt_q;
		pcnt_d         = pcnt_q;
		qcnt_d         = qcnt_q;
		err_d          = err_q;
		res.field_tag  = hrlp_pkg::TAG_NONE;
		res.char_index = 8'd0;
		res.char_value = byte_in;
		res.finished   = end_of_buffer;
		case (phase_q)
			hrlp_pkg::PH_METHOD: begin
				if (is_eol) begin
					err_d   = 1'b1;
					phase_d = hrlp_pkg::PH_DONE;
				end else if (byte_in == hrlp_pkg::CH_SP) begin
					phase_d = hrlp_pkg::PH_PATH;
				end else begin
					res.field_tag  = hrlp_pkg::TAG_METHOD;
					// position is below the limit, so it fits eight bits
					res.char_index = 8'(mpos - MW'(1));
					mcnt_d         = mpos;
					if (mpos >= MLIM) err_d = 1'b1;
				end
			end
			hrlp_pkg::PH_PATH: begin
				if (is_eol) begin
					err_d   = 1'b1;
					phase_d = hrlp_pkg::PH_DONE;
				end else if (byte_in == hrlp_pkg::CH_SP) begin
					phase_d = hrlp_pkg::PH_AFTER;
				end else if (byte_in == hrlp_pkg::CH_QM) begin
					phase_d = hrlp_pkg::PH_QUERY;
				end else begin
					res.field_tag  = hrlp_pkg::TAG_PATH;
					res.char_index = 8'(ppos - PW'(1));
					pcnt_d         = ppos;
					if (ppos >= PLIM) err_d = 1'b1;
				end
			end
			hrlp_pkg::PH_QUERY: begin
				if (is_eol) begin
					err_d   = 1'b1;
					phase_d = hrlp_pkg::PH_DONE;
				end else if (byte_in == hrlp_pkg::CH_SP) begin
					phase_d = hrlp_pkg::PH_AFTER;
				end else begin
					res.field_tag  = hrlp_pkg::TAG_QUERY;
					res.char_index = 8'(qpos - QW'(1));
					qcnt_d         = qpos;
					if (qpos >= QLIM) err_d = 1'b1;
				end
			end
			hrlp_pkg::PH_AFTER: begin
				if (is_eol) phase_d = hrlp_pkg::PH_DONE;
			end
			default: begin
			end
		endcase
		res.parse_failed = end_of_buffer && (err_d || (phase_d != hrlp_pkg::PH_DONE));
	end

	// state update, back to start after the last byte of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrlp_pkg::PH_METHOD;
			mcnt_q  <= '0;
			pcnt_q  <= '0;
			qcnt_q  <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			if (end_of_buffer) begin
				phase_q <= hrlp_pkg::PH_METHOD;
				mcnt_q  <= '0;
				pcnt_q  <= '0;
				qcnt_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				mcnt_q  <= mcnt_d;
				pcnt_q  <= pcnt_d;
				qcnt_q  <= qcnt_d;
				err_q   <= err_d;
			end
		end
	end

	assign at_start = (phase_q == hrlp_pkg::PH_METHOD) && (mcnt_q == '0) &&
		(pcnt_q == '0) && (qcnt_q == '0) && !err_q;

endmodule

/* hdl/http_request_line_parser_top.sv */
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// Splits the first line of an HTTP request, one byte per word, into method,
// path and query, tagging each byte with its field and position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request byte per word in s_tdata, s_tlast marks
//   the final byte of the request buffer.
//   Output channel m_*: one result word per input word, in order. m_tdata
//   carries tag, index and the echoed byte; m_tlast is set on the result of
//   the final byte, and m_tuser then reports a malformed or too long line.
//   Each accepted word waits in the input register, and the parse logic
//   loads the output register from it when that register is free or being
//   drained.
//   Throughput is one word per cycle without a stall; the phase and counter
//   registers in the core are updated in the same cycle a word moves into
//   the output register. On a receiver stall the output register holds
//   and the input register fills; s_tready drops only when both are full.
//   Reset empties both registers and returns the parser to the method phase.
//   After the final byte of a buffer the parser starts a new request.
// ----------------------------------------------------------------------------
module http_request_line_parser_top #(
	parameter int METHOD_LIMIT = 16,
	parameter int PATH_LIMIT   = 256,
	parameter int QUERY_LIMIT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tlast,   // end_of_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [1:0] field_tag, [9:2] char_index,
	                               // [17:10] char_value, [23:18] zero
	output logic        m_tlast,   // finished
	output logic        m_tuser    // parse_failed
);

	logic              vld_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              vld_s2;
	hrlp_pkg::result_t res_s2;
	hrlp_pkg::result_t res;
	logic              adv;
	logic              step;
	logic              at_start;

	// pipeline moves when the output register is free or being drained
	assign adv      = !vld_s2 || m_tready;
	assign step     = adv && vld_s1;
	assign s_tready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hrlp_core #(
		.METHOD_LIMIT(METHOD_LIMIT),
		.PATH_LIMIT  (PATH_LIMIT),
		.QUERY_LIMIT (QUERY_LIMIT)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.byte_in      (byte_s1),
		.end_of_buffer(last_s1),
		.res          (res),
		.at_start     (at_start)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {6'd0, res_s2.char_value, res_s2.char_index, res_s2.field_tag};
	assign m_tlast  = res_s2.finished;
	assign m_tuser  = res_s2.parse_failed;

	// failure is only reported on the final result
	a_fail_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("parse_failed without finished");

	// separators and ignored bytes carry index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == hrlp_pkg::TAG_NONE) |-> (m_tdata[9:2] == 8'd0))
		else $error("nonzero index on untagged byte");

	// method positions stay below the method limit
	a_method_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == hrlp_pkg::TAG_METHOD) |->
		(32'(m_tdata[9:2]) < METHOD_LIMIT))
		else $error("method index beyond limit");

	// parser returns to start after the final byte of a buffer
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> at_start)
		else $error("parser state not cleared after final byte");

endmodule
